@@ rtl/core/skt_pkg.sv @@
// Shared types and constants for the sorted key table.
// Holds the state encoding, command and status codes and the default depth.
// No dependencies.
`default_nettype none

package skt_pkg;

    // Default number of key slots
    localparam int DEFAULT_DEPTH = 16;

    // Fixed field widths
    localparam int KEY_W         = 32;
    localparam int ENTRY_COUNT_W = 7;

    // Command codes
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_DUMP   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CHK,
        S_DEL_RD,
        S_DEL_CHK,
        S_SHF_RD,
        S_SHF_WR,
        S_DMP_RD,
        S_DMP_EMIT,
        S_RESULT
    } t_state;

endpackage

`default_nettype wire

@@ rtl/core/sorted_key_table.sv @@
// Top level of the sorted key table: command sequencer, count and output register.
// Depends on skt_pkg and skt_key_ram.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+------------------------------------------
//  in      | i_in_valid  | o_in_ready  | i_command, i_key
//  out     | o_out_valid | i_out_ready | o_status, o_entry_key, o_entry_count, o_last
//
// One request at a time; each walk step is a RAM read and then a check.
// A synchronous reset clears the count and control state; the RAM needs no clearing.
// A stalled result stalls the sequencer only where it must emit.
`default_nettype none

module sorted_key_table #(
    parameter int DEPTH = skt_pkg::DEFAULT_DEPTH
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_in_valid,
    output logic                                          o_in_ready,
    input  wire logic [1:0]                               i_command,
    input  wire logic signed [skt_pkg::KEY_W-1:0]         i_key,
    output logic                                          o_out_valid,
    input  wire logic                                     i_out_ready,
    output logic [1:0]                                    o_status,
    output logic signed [skt_pkg::KEY_W-1:0]              o_entry_key,
    output logic [skt_pkg::ENTRY_COUNT_W-1:0]             o_entry_count,
    output logic                                          o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    skt_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_pos, n_pos;
    logic signed [skt_pkg::KEY_W-1:0] r_key, n_key;
    skt_pkg::t_status r_res, n_res;

    logic                             r_out_valid;
    skt_pkg::t_status                 r_status;
    logic signed [skt_pkg::KEY_W-1:0] r_entry_key;
    logic [skt_pkg::ENTRY_COUNT_W-1:0] r_entry_count;
    logic                             r_last;

    logic                             w_accept;
    logic                             w_out_free;
    logic                             w_full;
    logic                             w_empty;
    logic [CW-1:0]                    w_pos_inc;
    logic [CW-1:0]                    w_pos_dec;
    logic                             w_key_gt;
    logic                             w_dump_last;
    skt_pkg::t_cmd                    w_cmd;

    logic                             w_emit;
    skt_pkg::t_status                 w_emit_status;
    logic signed [skt_pkg::KEY_W-1:0] w_emit_key;
    logic                             w_emit_last;

    logic                             w_we;
    logic [AW-1:0]                    w_waddr;
    logic signed [skt_pkg::KEY_W-1:0] w_wdata;
    logic                             w_re;
    logic [AW-1:0]                    w_raddr;
    logic signed [skt_pkg::KEY_W-1:0] w_rdata;

    skt_key_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Shared conditions
    assign w_cmd       = skt_pkg::t_cmd'(i_command);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_pos_inc   = r_pos + CW'(1);
    assign w_pos_dec   = r_pos - CW'(1);
    assign w_key_gt    = (r_key > w_rdata);
    assign w_dump_last = (w_pos_inc == r_count);
    assign o_in_ready  = (r_state == skt_pkg::S_IDLE);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            skt_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (w_cmd)
                        skt_pkg::CMD_INSERT: n_state = w_full ? skt_pkg::S_RESULT
                                                              : skt_pkg::S_INS_RD;
                        skt_pkg::CMD_DELETE: n_state = w_empty ? skt_pkg::S_RESULT
                                                               : skt_pkg::S_DEL_RD;
                        skt_pkg::CMD_DUMP:   n_state = w_empty ? skt_pkg::S_RESULT
                                                               : skt_pkg::S_DMP_RD;
                        skt_pkg::CMD_CLEAR:  n_state = skt_pkg::S_RESULT;
                        default:             n_state = skt_pkg::S_RESULT;
                    endcase
                end
            end
            skt_pkg::S_INS_RD: begin
                n_state = (r_pos == '0) ? skt_pkg::S_RESULT : skt_pkg::S_INS_CHK;
            end
            skt_pkg::S_INS_CHK: begin
                n_state = w_key_gt ? skt_pkg::S_RESULT : skt_pkg::S_INS_RD;
            end
            skt_pkg::S_DEL_RD: begin
                n_state = (r_pos == r_count) ? skt_pkg::S_RESULT : skt_pkg::S_DEL_CHK;
            end
            skt_pkg::S_DEL_CHK: begin
                if (w_key_gt) begin
                    n_state = skt_pkg::S_DEL_RD;
                end else if (w_rdata != r_key) begin
                    n_state = skt_pkg::S_RESULT;
                end else begin
                    n_state = skt_pkg::S_SHF_RD;
                end
            end
            skt_pkg::S_SHF_RD: begin
                n_state = (w_pos_inc >= r_count) ? skt_pkg::S_RESULT : skt_pkg::S_SHF_WR;
            end
            skt_pkg::S_SHF_WR: begin
                n_state = skt_pkg::S_SHF_RD;
            end
            skt_pkg::S_DMP_RD: begin
                n_state = skt_pkg::S_DMP_EMIT;
            end
            skt_pkg::S_DMP_EMIT: begin
                if (w_out_free) begin
                    n_state = w_dump_last ? skt_pkg::S_IDLE : skt_pkg::S_DMP_RD;
                end
            end
            skt_pkg::S_RESULT: begin
                if (w_out_free) begin
                    n_state = skt_pkg::S_IDLE;
                end
            end
            default: n_state = skt_pkg::S_IDLE;
        endcase
    end

    // Datapath, RAM control and result emission per state
    always_comb begin
        n_count       = r_count;
        n_pos         = r_pos;
        n_key         = r_key;
        n_res         = r_res;
        w_we          = 1'b0;
        w_waddr       = r_pos[AW-1:0];
        w_wdata       = r_key;
        w_re          = 1'b0;
        w_raddr       = r_pos[AW-1:0];
        w_emit        = 1'b0;
        w_emit_status = r_res;
        w_emit_key    = '0;
        w_emit_last   = 1'b1;
        unique case (r_state)
            skt_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_key = i_key;
                    n_res = skt_pkg::ST_OK;
                    n_pos = '0;
                    unique case (w_cmd)
                        skt_pkg::CMD_INSERT: begin
                            if (w_full) begin
                                n_res = skt_pkg::ST_FULL;
                            end else begin
                                n_pos = r_count;
                            end
                        end
                        skt_pkg::CMD_DELETE, skt_pkg::CMD_DUMP: begin
                            if (w_empty) begin
                                n_res = skt_pkg::ST_EMPTY;
                            end
                        end
                        skt_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: n_res = skt_pkg::ST_OK;
                    endcase
                end
            end
            skt_pkg::S_INS_RD: begin
                // Bottom reached: the key takes slot zero
                if (r_pos == '0) begin
                    w_we    = 1'b1;
                    n_count = r_count + CW'(1);
                    n_res   = skt_pkg::ST_OK;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = w_pos_dec[AW-1:0];
                end
            end
            skt_pkg::S_INS_CHK: begin
                // Place the key above a smaller one, else move the entry up
                w_we = 1'b1;
                if (w_key_gt) begin
                    n_count = r_count + CW'(1);
                    n_res   = skt_pkg::ST_OK;
                end else begin
                    w_wdata = w_rdata;
                    n_pos   = w_pos_dec;
                end
            end
            skt_pkg::S_DEL_RD: begin
                if (r_pos == r_count) begin
                    n_res = skt_pkg::ST_NOT_FOUND;
                end else begin
                    w_re = 1'b1;
                end
            end
            skt_pkg::S_DEL_CHK: begin
                if (w_key_gt) begin
                    n_pos = w_pos_inc;
                end else if (w_rdata != r_key) begin
                    n_res = skt_pkg::ST_NOT_FOUND;
                end
            end
            skt_pkg::S_SHF_RD: begin
                // Close the gap one slot at a time, then drop the count
                if (w_pos_inc >= r_count) begin
                    n_count = r_count - CW'(1);
                    n_res   = skt_pkg::ST_OK;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = w_pos_inc[AW-1:0];
                end
            end
            skt_pkg::S_SHF_WR: begin
                w_we    = 1'b1;
                w_wdata = w_rdata;
                n_pos   = w_pos_inc;
            end
            skt_pkg::S_DMP_RD: begin
                w_re = 1'b1;
            end
            skt_pkg::S_DMP_EMIT: begin
                if (w_out_free) begin
                    w_emit        = 1'b1;
                    w_emit_status = skt_pkg::ST_OK;
                    w_emit_key    = w_rdata;
                    w_emit_last   = w_dump_last;
                    n_pos         = w_pos_inc;
                end
            end
            skt_pkg::S_RESULT: begin
                w_emit = w_out_free;
            end
            default: n_res = r_res;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skt_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_key <= n_key;
        r_res <= n_res;
    end

    // Output register: load on emit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_status      <= w_emit_status;
            r_entry_key   <= w_emit_key;
            r_entry_count <= skt_pkg::ENTRY_COUNT_W'(n_count);
            r_last        <= w_emit_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_key   = r_entry_key;
    assign o_entry_count = r_entry_count;
    assign o_last        = r_last;

`ifndef ASSERT_OFF
    // A refused insert reports a full table
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == skt_pkg::ST_FULL) |->
            (o_entry_count == skt_pkg::ENTRY_COUNT_W'(DEPTH)))
        else $error("full status with table not full");

    // Only a dump gives results that are not the final one
    a_not_last_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |->
            (o_status == skt_pkg::ST_OK && o_entry_count > 1))
        else $error("non-final result outside a dump");

    // The RAM is written only by insert and by closing a gap
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == skt_pkg::S_INS_RD || r_state == skt_pkg::S_INS_CHK ||
                  r_state == skt_pkg::S_SHF_WR))
        else $error("RAM write outside insert or shift");

    // An accepted request always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != skt_pkg::S_IDLE))
        else $error("accepted request left sequencer idle");
`endif

endmodule

`default_nettype wire

@@ rtl/core/skt_key_ram.sv @@
// Key store of the sorted key table: one write port, one registered read port.
// Read data is registered: it appears in the cycle after a read enable and holds until the next one.
// Uses skt_pkg for the key width.
`default_nettype none

module skt_key_ram #(
    parameter int DEPTH = skt_pkg::DEFAULT_DEPTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [AW-1:0]                    i_waddr,
    input  wire logic signed [skt_pkg::KEY_W-1:0] i_wdata,
    input  wire logic                             i_re,
    input  wire logic [AW-1:0]                    i_raddr,
    output logic signed [skt_pkg::KEY_W-1:0]      o_rdata
);

    logic signed [skt_pkg::KEY_W-1:0] r_mem [DEPTH];

    // Write the addressed slot
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read data, hold it between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ dv/tb_sorted_key_table.sv @@
`timescale 1ns / 1ps
// Testbench for sorted_key_table: directed and random command requests checked against a
// shadow copy of the ordered key table kept in the bench. Depends on skt_pkg and the RTL.

module tb_sorted_key_table;

    localparam int DEPTH    = skt_pkg::DEFAULT_DEPTH;
    localparam int LIMIT_NS = 5_000_000;

    typedef logic signed [skt_pkg::KEY_W-1:0] t_key;

    typedef struct packed {
        skt_pkg::t_status                  status;
        t_key                              entry_key;
        logic [skt_pkg::ENTRY_COUNT_W-1:0] entry_count;
        logic                              last;
    } t_table_result;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_ready;
    logic [1:0]                        i_command;
    t_key                              i_key;
    logic                              o_out_valid;
    logic                              i_out_ready;
    logic [1:0]                        o_status;
    t_key                              o_entry_key;
    logic [skt_pkg::ENTRY_COUNT_W-1:0] o_entry_count;
    logic                              o_last;

    // Shadow of the stored keys, ascending, and the results still owed by the block
    t_key          shadow_keys[$];
    t_table_result owed_results[$];
    int            error_count = 0;
    bit            quiet_mode  = 1'b0;

    sorted_key_table #(.DEPTH(DEPTH)) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_key        (i_key),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_entry_key  (o_entry_key),
        .o_entry_count(o_entry_count),
        .o_last       (o_last)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #(LIMIT_NS);
        $display("FAIL sorted_key_table");
        $finish;
    end

    // Queue one expected result at the current table size
    function automatic void owe_result(skt_pkg::t_status status, t_key entry_key, logic last);
        t_table_result r;
        r.status      = status;
        r.entry_key   = entry_key;
        r.entry_count = skt_pkg::ENTRY_COUNT_W'(shadow_keys.size());
        r.last        = last;
        owed_results.push_back(r);
    endfunction

    // Apply one accepted request to the shadow table and queue its results
    function automatic void apply_table_request(skt_pkg::t_cmd cmd, t_key key);
        int pos;
        pos = 0;
        case (cmd)
            skt_pkg::CMD_INSERT: begin
                if (shadow_keys.size() >= DEPTH) begin
                    owe_result(skt_pkg::ST_FULL, '0, 1'b1);
                end else begin
                    while (pos < shadow_keys.size() && key > shadow_keys[pos]) pos++;
                    shadow_keys.insert(pos, key);
                    owe_result(skt_pkg::ST_OK, '0, 1'b1);
                end
            end
            skt_pkg::CMD_DELETE: begin
                if (shadow_keys.size() == 0) begin
                    owe_result(skt_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    while (pos < shadow_keys.size() && key > shadow_keys[pos]) pos++;
                    if (pos >= shadow_keys.size() || shadow_keys[pos] != key) begin
                        owe_result(skt_pkg::ST_NOT_FOUND, '0, 1'b1);
                    end else begin
                        shadow_keys.delete(pos);
                        owe_result(skt_pkg::ST_OK, '0, 1'b1);
                    end
                end
            end
            skt_pkg::CMD_DUMP: begin
                if (shadow_keys.size() == 0) begin
                    owe_result(skt_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    foreach (shadow_keys[i])
                        owe_result(skt_pkg::ST_OK, shadow_keys[i],
                                   i == shadow_keys.size() - 1);
                end
            end
            default: begin
                shadow_keys.delete();
                owe_result(skt_pkg::ST_OK, '0, 1'b1);
            end
        endcase
    endfunction

    // Drive one request after a random gap, none in quiet mode, and hold it until accepted
    task automatic send_request(skt_pkg::t_cmd cmd, t_key key);
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, 5);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_key      <= key;
        do @(posedge i_clk); while (!o_in_ready);
        apply_table_request(cmd, key);
    endtask

    // Drop valid and hold off until every owed result has arrived
    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
    endtask

    // Result side: random stall before each result, none in quiet mode, then compare with the oldest owed one
    initial begin
        int            stall;
        t_table_result want;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = quiet_mode ? 0 : $urandom_range(0, 5);
            @(negedge i_clk);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result: status=%0d key=%0d count=%0d last=%0d",
                         $realtime, o_status, o_entry_key, o_entry_count, o_last);
                error_count++;
            end else begin
                want = owed_results.pop_front();
                if (o_status !== want.status || o_entry_key !== want.entry_key ||
                    o_entry_count !== want.entry_count || o_last !== want.last) begin
                    $display("%0t: mismatch: expected status=%0d key=%0d count=%0d last=%0d",
                             $realtime, want.status, want.entry_key, want.entry_count,
                             want.last);
                    $display("%0t:           actual   status=%0d key=%0d count=%0d last=%0d",
                             $realtime, o_status, o_entry_key, o_entry_count, o_last);
                    error_count++;
                end
            end
        end
    end

    // Requests on a table that has never held a key
    task automatic test_empty_table();
        send_request(skt_pkg::CMD_DUMP, 32'sd5);
        send_request(skt_pkg::CMD_DELETE, 32'sd0);
        send_request(skt_pkg::CMD_CLEAR, -32'sd1);
    endtask

    // Extreme keys, a duplicate, a missing key and deletion of the first of two equals
    task automatic test_key_extremes();
        send_request(skt_pkg::CMD_INSERT, 32'sh7FFF_FFFF);
        send_request(skt_pkg::CMD_INSERT, 32'sh8000_0000);
        send_request(skt_pkg::CMD_INSERT, 32'sd0);
        send_request(skt_pkg::CMD_INSERT, -32'sd1);
        send_request(skt_pkg::CMD_INSERT, 32'sh7FFF_FFFF);
        send_request(skt_pkg::CMD_DELETE, 32'sd1);
        send_request(skt_pkg::CMD_DELETE, 32'sh7FFF_FFFF);
    endtask

    // Fill to capacity, refuse one more insert, dump all and remove from both ends
    task automatic test_full_table();
        while (shadow_keys.size() < DEPTH)
            send_request(skt_pkg::CMD_INSERT, t_key'($urandom));
        send_request(skt_pkg::CMD_INSERT, 32'sd42);
        send_request(skt_pkg::CMD_DUMP, 32'sd0);
        send_request(skt_pkg::CMD_DELETE, 32'sh8000_0000);
        send_request(skt_pkg::CMD_DELETE, shadow_keys[shadow_keys.size() - 1]);
    endtask

    // Random command mix; keys mostly from the table or a narrow range so deletes hit
    task automatic run_random_requests(int count);
        int            pick;
        skt_pkg::t_cmd cmd;
        t_key          key;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 42)      cmd = skt_pkg::CMD_INSERT;
            else if (pick < 77) cmd = skt_pkg::CMD_DELETE;
            else if (pick < 94) cmd = skt_pkg::CMD_DUMP;
            else                cmd = skt_pkg::CMD_CLEAR;
            pick = $urandom_range(0, 2);
            if (pick == 0 && shadow_keys.size() != 0)
                key = shadow_keys[$urandom_range(0, shadow_keys.size() - 1)];
            else if (pick == 1)
                key = t_key'($signed($urandom_range(0, 16)) - 8);
            else
                key = t_key'($urandom);
            send_request(cmd, key);
        end
    endtask

    // Random phases with and without idling, with a full drain between them
    task automatic test_random_mix();
        run_random_requests(30);
        wait_for_results();
        quiet_mode = 1'b1;
        run_random_requests(24);
        wait_for_results();
        quiet_mode = 1'b0;
        run_random_requests(30);
    endtask

    // Reset, run every test, then drain and report
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_command   = skt_pkg::CMD_INSERT;
        i_key       = '0;
        i_out_ready = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_key_extremes();
        test_full_table();
        test_random_mix();

        wait_for_results();
        repeat (60) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS sorted_key_table");
        end else begin
            $display("FAIL sorted_key_table");
        end
        $finish;
    end

endmodule
